>>> hw/rtl/rvpd_pkg.sv
// rvpd_pkg: shared constants and types for the radial vignette pixel darken block
// no dependencies; imported by radial_vignette_pixel_darken
`default_nettype none

package rvpd_pkg;

    localparam int unsigned MAX_DIM_DEF = 4096;

    localparam int unsigned COORD_W    = 12;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned STR_W      = 12;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    // quotient bits kept by the divider; anything larger saturates
    localparam int unsigned QW = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

    localparam logic [STR_W-1:0] STRENGTH_RST = 12'd0;
    localparam logic [DIM_W-1:0] WIDTH_RST    = 13'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RST   = 13'd240;

    typedef logic [CH_W-1:0] t_ch;

    typedef struct packed {
        t_ch  red;
        t_ch  green;
        t_ch  blue;
        t_ch  cov;
        logic use_cov;
    } t_pix;

endpackage

`default_nettype wire

>>> hw/rtl/radial_vignette_pixel_darken.sv
// radial_vignette_pixel_darken: pipelined radial vignette on one pixel per clock
// depends on rvpd_pkg
`default_nettype none

// Usage
//   Input channel: drive the pixel fields and raise start; a transaction is taken
//   at every clock edge with start high and busy low. busy is always low, so a
//   new pixel may enter on every clock.
//   Result channel: o_valid is high for exactly one cycle with the three output
//   channels; there is no back-pressure, the receiver must take it then.
//   Config channel: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
//   always high. Index 0 strength, 1 image width, 2 image height, 3 ignored.
//   Write config only while no pixel is in flight.
//   Order: the accepting edge loads stage 1; the pixel then passes the squares,
//   sum, strength multiply, divider and color stages, and the result registers
//   with o_valid in the output stage.
//   Throughput: one pixel per cycle. Depth is set by the 9-stage divider
//   (saturation check, then one quotient bit per stage) plus the distance,
//   squaring, sum, strength multiply, two color stages and the output stage.
//   Reset: synchronous active-low; clears all valid bits and restores the
//   registers to strength 0, 320 x 240. Pixels in flight are dropped.
module radial_vignette_pixel_darken
    import rvpd_pkg::*;
#(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [COORD_W-1:0]    i_pixel_x,
    input  wire logic [COORD_W-1:0]    i_pixel_y,
    input  wire logic [CH_W-1:0]       i_red_in,
    input  wire logic [CH_W-1:0]       i_green_in,
    input  wire logic [CH_W-1:0]       i_blue_in,
    input  wire logic [CH_W-1:0]       i_coverage,
    input  wire logic                  i_use_coverage,

    output      logic                  o_valid,
    output      logic [CH_W-1:0]       o_red_out,
    output      logic [CH_W-1:0]       o_green_out,
    output      logic [CH_W-1:0]       o_blue_out,

    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // image size is capped by MAX_DIM and by the register width
    localparam int unsigned DIM_MAXV = (1 << DIM_W) - 1;
    localparam int unsigned DIM_CAP  = (MAX_DIM < DIM_MAXV) ? MAX_DIM : DIM_MAXV;
    localparam int unsigned CW       = $clog2(DIM_CAP / 2 + 1);
    localparam int unsigned MW       = 2 * CW + 1;
    localparam int unsigned SQW      = 2 * COORD_W;
    localparam int unsigned D2W      = SQW + 1;
    localparam int unsigned PW       = STR_W + D2W;

    // ---------------- configuration ----------------
    logic [STR_W-1:0] r_strength;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= STRENGTH_RST;
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_STRENGTH: r_strength <= i_cfg_data[STR_W-1:0];
                REG_WIDTH:    r_width    <= i_cfg_data;
                REG_HEIGHT:   r_height   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_wsat, w_hsat;
    logic [CW-1:0]    w_cx, w_cy;

    assign w_wsat = (r_width  > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : r_width;
    assign w_hsat = (r_height > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : r_height;
    assign w_cx   = CW'(w_wsat >> 1);
    assign w_cy   = CW'(w_hsat >> 1);

    // corner distance follows the registers through r_cx2 / r_cy2 and then r_maxd2;
    // the user must keep config quiet while a pixel is in flight; the block itself does not enforce it
    logic [2*CW-1:0] r_cx2, r_cy2;
    logic [MW-1:0]   r_maxd2;
    logic [MW-1:0]   n_maxd2;

    assign n_maxd2 = MW'(r_cx2) + MW'(r_cy2);

    always_ff @(posedge i_clk) begin
        r_cx2   <= w_cx * w_cx;
        r_cy2   <= w_cy * w_cy;
        r_maxd2 <= (n_maxd2 == '0) ? MW'(1) : n_maxd2;
    end

    // ---------------- stage 1: distance from center ----------------
    logic               r_s1_vld;
    logic [COORD_W-1:0] r_s1_dx, r_s1_dy;
    t_pix               r_s1_pix;
    logic [COORD_W-1:0] w_cxe, w_cye;
    t_pix               w_in_pix;

    assign w_cxe    = COORD_W'(w_cx);
    assign w_cye    = COORD_W'(w_cy);
    assign w_in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in,
                        cov: i_coverage, use_cov: i_use_coverage};

    always_ff @(posedge i_clk) begin
        r_s1_dx  <= (i_pixel_x >= w_cxe) ? i_pixel_x - w_cxe : w_cxe - i_pixel_x;
        r_s1_dy  <= (i_pixel_y >= w_cye) ? i_pixel_y - w_cye : w_cye - i_pixel_y;
        r_s1_pix <= w_in_pix;
    end

    // ---------------- stage 2: squares ----------------
    logic           r_s2_vld;
    logic [SQW-1:0] r_s2_dx2, r_s2_dy2;
    t_pix           r_s2_pix;

    always_ff @(posedge i_clk) begin
        r_s2_dx2 <= r_s1_dx * r_s1_dx;
        r_s2_dy2 <= r_s1_dy * r_s1_dy;
        r_s2_pix <= r_s1_pix;
    end

    // ---------------- stage 3: squared distance ----------------
    logic           r_s3_vld;
    logic [D2W-1:0] r_s3_d2;
    t_pix           r_s3_pix;

    always_ff @(posedge i_clk) begin
        r_s3_d2  <= D2W'(r_s2_dx2) + D2W'(r_s2_dy2);
        r_s3_pix <= r_s2_pix;
    end

    // ---------------- stage 4: scaled by strength ----------------
    logic          r_s4_vld;
    logic [PW-1:0] r_s4_p;
    t_pix          r_s4_pix;

    always_ff @(posedge i_clk) begin
        r_s4_p   <= PW'(r_strength) * PW'(r_s3_d2);
        r_s4_pix <= r_s3_pix;
    end

    // ---------------- divider: saturation check then one bit per stage ----------------
    logic          r_div_vld [0:QW];
    logic [PW-1:0] r_div_rem [0:QW];
    logic [QW-1:0] r_div_q   [0:QW];
    logic          r_div_sat [0:QW];
    t_pix          r_div_pix [0:QW];

    always_ff @(posedge i_clk) begin
        r_div_rem[0] <= r_s4_p;
        r_div_q[0]   <= '0;
        // quotient of 256 or more clamps to 255
        r_div_sat[0] <= r_s4_p >= (PW'(r_maxd2) << QW);
        r_div_pix[0] <= r_s4_pix;
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int unsigned B = QW - j;
        logic [PW-1:0] n_sub;
        logic          n_bit;

        assign n_sub = PW'(r_maxd2) << B;
        assign n_bit = r_div_rem[j-1] >= n_sub;

        always_ff @(posedge i_clk) begin
            r_div_rem[j]    <= n_bit ? r_div_rem[j-1] - n_sub : r_div_rem[j-1];
            r_div_q[j]      <= r_div_q[j-1] | (QW'(n_bit) << B);
            r_div_sat[j]    <= r_div_sat[j-1];
            r_div_pix[j]    <= r_div_pix[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[j] <= 1'b0;
            end else begin
                r_div_vld[j] <= r_div_vld[j-1];
            end
        end
    end

    // ---------------- color stage 1: scaled channels ----------------
    t_ch  w_dark, w_f;
    t_ch  w_old [0:2];
    logic r_c1_vld;
    t_ch  r_c1_nv [0:2];
    t_pix r_c1_pix;

    assign w_dark   = r_div_sat[QW] ? '1 : r_div_q[QW];
    assign w_f      = 8'hFF - w_dark;
    assign w_old[0] = r_div_pix[QW].red;
    assign w_old[1] = r_div_pix[QW].green;
    assign w_old[2] = r_div_pix[QW].blue;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_c1_nv[k] <= CH_W'((2*CH_W)'(w_old[k] * w_f) >> CH_W);
        end
        r_c1_pix <= r_div_pix[QW];
    end

    // ---------------- color stage 2: coverage blend product ----------------
    t_ch             w_c1_old [0:2];
    logic            r_c2_vld;
    t_ch             r_c2_nv [0:2];
    logic [2*CH_W-1:0] r_c2_prod [0:2];
    t_pix            r_c2_pix;

    assign w_c1_old[0] = r_c1_pix.red;
    assign w_c1_old[1] = r_c1_pix.green;
    assign w_c1_old[2] = r_c1_pix.blue;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_c2_prod[k] <= (w_c1_old[k] - r_c1_nv[k]) * r_c1_pix.cov;
            r_c2_nv[k]   <= r_c1_nv[k];
        end
        r_c2_pix <= r_c1_pix;
    end

    // ---------------- output stage ----------------
    t_ch             w_c2_old [0:2];
    t_ch             n_res    [0:2];
    logic [2*CH_W:0] w_round  [0:2];

    assign w_c2_old[0] = r_c2_pix.red;
    assign w_c2_old[1] = r_c2_pix.green;
    assign w_c2_old[2] = r_c2_pix.blue;

    // floor of a negative step, done on its magnitude by rounding up
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_round[k] = (2*CH_W+1)'(r_c2_prod[k]) + (2*CH_W+1)'(8'hFF);
            n_res[k]   = r_c2_pix.use_cov ? w_c2_old[k] - CH_W'(w_round[k] >> CH_W)
                                          : r_c2_nv[k];
        end
    end

    always_ff @(posedge i_clk) begin
        o_red_out   <= n_res[0];
        o_green_out <= n_res[1];
        o_blue_out  <= n_res[2];
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_s4_vld     <= 1'b0;
            r_div_vld[0] <= 1'b0;
            r_c1_vld     <= 1'b0;
            r_c2_vld     <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_s1_vld     <= start && !busy;
            r_s2_vld     <= r_s1_vld;
            r_s3_vld     <= r_s2_vld;
            r_s4_vld     <= r_s3_vld;
            r_div_vld[0] <= r_s4_vld;
            r_c1_vld     <= r_div_vld[QW];
            r_c2_vld     <= r_c1_vld;
            o_valid      <= r_c2_vld;
        end
    end

    // ---------------- assertions ----------------
    // a pixel leaving the divider shows up at the outputs after the two color stages and the output register
    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_vld[QW] |=> ##2 o_valid)
        else $error("divider output lost before result strobe");

    // darkening never brightens a channel
    a_no_brighten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c1_vld |-> (r_c1_nv[0] <= r_c1_pix.red) && (r_c1_nv[1] <= r_c1_pix.green)
                  && (r_c1_nv[2] <= r_c1_pix.blue))
        else $error("scaled channel exceeds input channel");

    // a saturated quotient means full darkening
    a_sat_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_vld[QW] && r_div_sat[QW] |=>
            (r_c1_nv[0] == '0) && (r_c1_nv[1] == '0) && (r_c1_nv[2] == '0))
        else $error("saturated darkening left a nonzero channel");

endmodule

`default_nettype wire
